### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check: antecedent holds, consequent in the same cycle
`define CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// concurrent check: antecedent holds, consequent in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### design/psbv_pkg.sv
`default_nettype none

package psbv_pkg;

  localparam int COORD_BITS = 32;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int ACC_BITS   = SQ_BITS + 2;
  localparam int ROOT_STEPS = COORD_BITS;
  localparam int CNT_BITS   = $clog2(ROOT_STEPS);

  localparam logic [COORD_BITS-1:0] COORD_POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_NEG_MAX = {1'b1, {(COORD_BITS-1){1'b0}}};

  // corner k takes the high bound on an axis where bit k is set
  localparam logic [7:0] SEL_X = 8'h6C;
  localparam logic [7:0] SEL_Y = 8'hC6;
  localparam logic [7:0] SEL_Z = 8'hF0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   final_vertex;
  } vertex_t;

  typedef struct packed {
    coord_t                  corner_x;
    coord_t                  corner_y;
    coord_t                  corner_z;
    coord_t                  centre_x;
    coord_t                  centre_y;
    coord_t                  centre_z;
    logic [COORD_BITS-2:0]   radius;
    logic                    final_corner;
  } corner_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } bounds_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_EMIT
  } back_state_t;

  function automatic bounds_t bounds_reset();
    bounds_t b;
    b.lo_x = COORD_POS_MAX;
    b.lo_y = COORD_POS_MAX;
    b.lo_z = COORD_POS_MAX;
    b.hi_x = COORD_NEG_MAX;
    b.hi_y = COORD_NEG_MAX;
    b.hi_z = COORD_NEG_MAX;
    return b;
  endfunction

  function automatic logic [COORD_BITS-1:0] abs_diff(coord_t hi, coord_t lo);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    d = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
    m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
    return m[COORD_BITS-1:0];
  endfunction

  function automatic coord_t centre_of(coord_t lo, coord_t hi);
    logic signed [COORD_BITS:0]   d;
    logic signed [COORD_BITS:0]   half;
    logic signed [COORD_BITS+1:0] c;
    d    = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
    half = d >>> 1;
    c    = $signed({{2{hi[COORD_BITS-1]}}, hi}) - $signed({half[COORD_BITS], half});
    if (c > $signed({2'b00, COORD_POS_MAX})) begin
      return COORD_POS_MAX;
    end else if (c < $signed({2'b11, COORD_NEG_MAX})) begin
      return COORD_NEG_MAX;
    end
    return c[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### design/psbv_queue.sv
`default_nettype none

module psbv_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  psbv_pkg::bounds_t push_data,
  output logic              full,
  output logic              head_valid,
  output psbv_pkg::bounds_t head,
  input  wire               pop
);
  import psbv_pkg::*;

  bounds_t    slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### design/psbv_front.sv
`default_nettype none

module psbv_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               vtx_valid,
  output logic              vtx_stall,
  input  psbv_pkg::vertex_t vtx,
  input  wire               q_full,
  output logic              push,
  output psbv_pkg::bounds_t push_data
);
  import psbv_pkg::*;

  bounds_t bnd;
  bounds_t bnd_next;
  logic    accept;

  assign vtx_stall = q_full;
  assign accept    = vtx_valid && !vtx_stall;
  assign push      = accept && vtx.final_vertex;
  assign push_data = bnd_next;

  always_comb begin
    bnd_next      = bnd;
    bnd_next.lo_x = (vtx.pos_x < bnd.lo_x) ? vtx.pos_x : bnd.lo_x;
    bnd_next.lo_y = (vtx.pos_y < bnd.lo_y) ? vtx.pos_y : bnd.lo_y;
    bnd_next.lo_z = (vtx.pos_z < bnd.lo_z) ? vtx.pos_z : bnd.lo_z;
    bnd_next.hi_x = (vtx.pos_x > bnd.hi_x) ? vtx.pos_x : bnd.hi_x;
    bnd_next.hi_y = (vtx.pos_y > bnd.hi_y) ? vtx.pos_y : bnd.hi_y;
    bnd_next.hi_z = (vtx.pos_z > bnd.hi_z) ? vtx.pos_z : bnd.hi_z;
  end

  // restart the bounds once a set is closed
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd <= bounds_reset();
    end else if (accept) begin
      bnd <= vtx.final_vertex ? bounds_reset() : bnd_next;
    end
  end

endmodule

`default_nettype wire

### design/psbv_back.sv
`default_nettype none

module psbv_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               head_valid,
  input  psbv_pkg::bounds_t head,
  output logic              pop,
  output logic              box_valid,
  input  wire               box_stall,
  output psbv_pkg::corner_t box
);
  import psbv_pkg::*;

  back_state_t            state;
  back_state_t            state_next;
  logic [CNT_BITS-1:0]    cnt;
  logic [2:0]             k;
  logic                   load;

  bounds_t                bnd;
  logic [COORD_BITS-1:0]  ad [3];
  logic [SQ_BITS-1:0]     sq;
  logic [ACC_BITS-1:0]    acc;
  logic [ACC_BITS-1:0]    sum;
  logic [SQ_BITS-1:0]     t;
  logic [COORD_BITS+1:0]  rem;
  logic [COORD_BITS-1:0]  root;
  logic [COORD_BITS+3:0]  rem_sh;
  logic [COORD_BITS+3:0]  trial;
  logic [COORD_BITS+3:0]  rem_diff;
  logic                   take;
  coord_t                 cen_x;
  coord_t                 cen_y;
  coord_t                 cen_z;
  logic [COORD_BITS-2:0]  rad;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head_valid) state_next = ST_SQUARE;
      ST_SQUARE: if (cnt == CNT_BITS'(2)) state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (cnt == CNT_BITS'(ROOT_STEPS - 1)) state_next = ST_EMIT;
      ST_EMIT:   if (load && k == 3'd7) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      ST_IDLE: pop  = head_valid;
      ST_EMIT: load = !box_valid || !box_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      k         <= 3'd0;
      box_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state != state_next) ? '0 : cnt + CNT_BITS'(1);
      if (pop) begin
        k <= 3'd0;
      end else if (load) begin
        k <= k + 3'd1;
      end
      if (load) begin
        box_valid <= 1'b1;
      end else if (!box_stall) begin
        box_valid <= 1'b0;
      end
    end
  end

  assign sum      = acc + {2'b00, sq};
  assign rem_sh   = {rem, t[SQ_BITS-1 -: 2]};
  assign trial    = {2'b00, root, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign take     = (rem_sh >= trial);
  assign rad      = root[COORD_BITS-1] ? '1 : root[COORD_BITS-2:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      bnd   <= head;
      ad[0] <= abs_diff(head.hi_x, head.lo_x);
      ad[1] <= abs_diff(head.hi_y, head.lo_y);
      ad[2] <= abs_diff(head.hi_z, head.lo_z);
    end
    if (state == ST_SQUARE) begin
      sq  <= ad[cnt[1:0]] * ad[cnt[1:0]];
      acc <= (cnt == '0) ? '0 : sum;
    end
    if (state == ST_SUM) begin
      t     <= sum[ACC_BITS-1:2];
      rem   <= '0;
      root  <= '0;
      cen_x <= centre_of(bnd.lo_x, bnd.hi_x);
      cen_y <= centre_of(bnd.lo_y, bnd.hi_y);
      cen_z <= centre_of(bnd.lo_z, bnd.hi_z);
    end
    if (state == ST_ROOT) begin
      rem  <= take ? rem_diff[COORD_BITS+1:0] : rem_sh[COORD_BITS+1:0];
      root <= {root[COORD_BITS-2:0], take};
      t    <= {t[SQ_BITS-3:0], 2'b00};
    end
    if (load) begin
      box.corner_x     <= SEL_X[k] ? bnd.hi_x : bnd.lo_x;
      box.corner_y     <= SEL_Y[k] ? bnd.hi_y : bnd.lo_y;
      box.corner_z     <= SEL_Z[k] ? bnd.hi_z : bnd.lo_z;
      box.centre_x     <= cen_x;
      box.centre_y     <= cen_y;
      box.centre_z     <= cen_z;
      box.radius       <= rad;
      box.final_corner <= (k == 3'd7);
    end
  end

endmodule

`default_nettype wire

### design/point_set_bounding_volumes.sv
// Streams 3D vertices in signed Q16.16 and, on the vertex marked final, returns
// the eight corners of the axis-aligned box around the set, each with the box
// centre and the bounding-sphere radius (half-extent length, saturated). The
// front takes one vertex a cycle and updates the running bounds; closed sets
// wait in a two-entry queue, and vtx_stall rises only while that queue is full.
// The back works on one set at a time: it loads the set, squares the three spans
// in turn on the shared 32x32 squarer, sums them, runs the one-bit-a-step square
// root, then makes eight result transfers.
`default_nettype none

module point_set_bounding_volumes (
  input  wire               clk,
  input  wire               rst,
  input  wire               vtx_valid,
  output logic              vtx_stall,
  input  psbv_pkg::vertex_t vtx,
  output logic              box_valid,
  input  wire               box_stall,
  output psbv_pkg::corner_t box
);
  import psbv_pkg::*;

  logic    push;
  bounds_t push_data;
  logic    q_full;
  logic    head_valid;
  bounds_t head;
  logic    pop;

  psbv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  psbv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  psbv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box        (box)
  );

endmodule

`default_nettype wire

### design/psbv_checker.sv
`default_nettype none
`include "assert_macros.svh"

module psbv_checker (
  input wire               clk,
  input wire               rst,
  input wire               vtx_valid,
  input wire               vtx_stall,
  input psbv_pkg::vertex_t vtx,
  input wire               box_valid,
  input wire               box_stall,
  input psbv_pkg::corner_t box
);
  import psbv_pkg::*;

  logic [2:0]            seen;
  logic [COORD_BITS-2:0] last_radius;
  logic                  xfer;
  logic                  vtx_xfer;

  assign xfer     = box_valid && !box_stall;
  assign vtx_xfer = vtx_valid && !vtx_stall && vtx.final_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 3'd0;
    end else if (xfer) begin
      seen <= seen + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      last_radius <= box.radius;
    end
  end

  `CHK_NEXT(a_hold, clk, rst, box_valid && box_stall, box_valid && $stable(box))
  `CHK_SAME(a_last, clk, rst, xfer, box.final_corner == (seen == 3'd7))
  `CHK_SAME(a_rad, clk, rst, xfer && seen != 3'd0, box.radius == last_radius)
  `CHK_SAME(a_low, clk, rst, xfer && seen == 3'd0,
            box.centre_x >= box.corner_x && box.centre_y >= box.corner_y)
  `CHK_NEXT(a_fill, clk, rst, !vtx_stall && !vtx_xfer, !vtx_stall)

endmodule

bind point_set_bounding_volumes psbv_checker u_psbv_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psbv_pkg::*;

  localparam int CW = $bits(coord_t);
  localparam coord_t MOST_POS = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t MOST_NEG = {1'b1, {(CW-1){1'b0}}};
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  // bit 0 picks high x, bit 1 high y, bit 2 high z, in corner order
  localparam logic [2:0] CORNER_PICK [8] = '{
    3'b000, 3'b010, 3'b011, 3'b001, 3'b100, 3'b101, 3'b111, 3'b110
  };

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} spread_t;

  class box_tracker;
    coord_t  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    corner_t corners_due[$];
    int      mismatches;
    int      corners_checked;
    int      sets_closed;
    int      vertices_taken;

    function new();
      open_set();
    endfunction

    function void open_set();
      lo_x = MOST_POS;
      lo_y = MOST_POS;
      lo_z = MOST_POS;
      hi_x = MOST_NEG;
      hi_y = MOST_NEG;
      hi_z = MOST_NEG;
    endfunction

    function coord_t centre(coord_t lo, coord_t hi);
      longint span, half, mid;
      span = longint'(hi) - longint'(lo);
      half = span >>> 1;
      mid  = longint'(hi) - half;
      if (mid > longint'(MOST_POS)) mid = longint'(MOST_POS);
      if (mid < longint'(MOST_NEG)) mid = longint'(MOST_NEG);
      return coord_t'(mid);
    endfunction

    function logic [CW-1:0] span_of(coord_t lo, coord_t hi);
      longint span;
      span = longint'(hi) - longint'(lo);
      if (span < 0) span = -span;
      return span[CW-1:0];
    endfunction

    function logic [CW-2:0] half_diagonal();
      logic [2*CW+3:0] wx, wy, wz, sq_sum, twice;
      logic [CW-2:0]   r, trial;
      wx = (2*CW+4)'(span_of(lo_x, hi_x));
      wy = (2*CW+4)'(span_of(lo_y, hi_y));
      wz = (2*CW+4)'(span_of(lo_z, hi_z));
      sq_sum = wx * wx + wy * wy + wz * wz;
      r = '0;
      for (int b = CW - 2; b >= 0; b--) begin
        trial = r;
        trial[b] = 1'b1;
        twice = (2*CW+4)'({trial, 1'b0});
        if (twice * twice <= sq_sum) r = trial;
      end
      return r;
    endfunction

    function void close_set();
      corner_t       c;
      coord_t        mid_x, mid_y, mid_z;
      logic [CW-2:0] rad;
      mid_x = centre(lo_x, hi_x);
      mid_y = centre(lo_y, hi_y);
      mid_z = centre(lo_z, hi_z);
      rad   = half_diagonal();
      for (int k = 0; k < 8; k++) begin
        c.corner_x     = CORNER_PICK[k][0] ? hi_x : lo_x;
        c.corner_y     = CORNER_PICK[k][1] ? hi_y : lo_y;
        c.corner_z     = CORNER_PICK[k][2] ? hi_z : lo_z;
        c.centre_x     = mid_x;
        c.centre_y     = mid_y;
        c.centre_z     = mid_z;
        c.radius       = rad;
        c.final_corner = (k == 7);
        corners_due    = {corners_due, c};
      end
      sets_closed++;
      open_set();
    endfunction

    function void note_vertex(vertex_t v);
      vertices_taken++;
      if (v.pos_x < lo_x) lo_x = v.pos_x;
      if (v.pos_y < lo_y) lo_y = v.pos_y;
      if (v.pos_z < lo_z) lo_z = v.pos_z;
      if (v.pos_x > hi_x) hi_x = v.pos_x;
      if (v.pos_y > hi_y) hi_y = v.pos_y;
      if (v.pos_z > hi_z) hi_z = v.pos_z;
      if (v.final_vertex) close_set();
    endfunction

    function void compare(string field, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got === want) return;
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s of corner result %0d: expected %h, got %h",
                 field, corners_checked, want, got);
    endfunction

    function void check_corner(corner_t got);
      corner_t want;
      corners_checked++;
      if (corners_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("corner result %0d arrived with none due: %p", corners_checked, got);
        return;
      end
      want = corners_due.pop_front();
      compare("corner_x", want.corner_x, got.corner_x);
      compare("corner_y", want.corner_y, got.corner_y);
      compare("corner_z", want.corner_z, got.corner_z);
      compare("centre_x", want.centre_x, got.centre_x);
      compare("centre_y", want.centre_y, got.centre_y);
      compare("centre_z", want.centre_z, got.centre_z);
      compare("radius", CW'(want.radius), CW'(got.radius));
      compare("final_corner", CW'(want.final_corner), CW'(got.final_corner));
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    vtx_valid = 1'b0;
  logic    vtx_stall;
  vertex_t vtx = '0;
  logic    box_valid;
  logic    box_stall = 1'b0;
  corner_t box;

  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  box_tracker tracker;

  point_set_bounding_volumes uut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box       (box)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      box_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= LONG_HOLD - 1;
      box_stall  <= 1'b1;
    end else begin
      box_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && box_valid && !box_stall) tracker.check_corner(box);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run timed out after %0d cycles", cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
    vertex_t v;
    v.pos_x = x;
    v.pos_y = y;
    v.pos_z = z;
    v.final_vertex = last;
    vtx <= v;
    vtx_valid <= 1'b1;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    tracker.note_vertex(v);
    if ($urandom_range(99) < sender_idle_pct) begin
      vtx_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    vtx_valid <= 1'b0;
    @(posedge clk);
    while (tracker.corners_due.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t pick_coord(spread_t spread, coord_t anchor);
    case (spread)
      SPREAD_FULL: return coord_t'($urandom);
      SPREAD_NEAR: return anchor + coord_t'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return MOST_POS;
          1: return MOST_NEG;
          2: return '0;
          3: return -1;
          4: return MOST_POS - coord_t'($urandom_range(0, 255));
          default: return MOST_NEG + coord_t'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  task automatic send_random_set();
    int      size;
    spread_t spread;
    coord_t  ax, ay, az;
    size = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
    spread = spread_t'($urandom_range(0, 2));
    ax = coord_t'($urandom);
    ay = coord_t'($urandom);
    az = coord_t'($urandom);
    for (int i = 0; i < size; i++)
      send_vertex(pick_coord(spread, ax), pick_coord(spread, ay), pick_coord(spread, az),
                  i == size - 1);
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 11;
    recv_idle_pct <= 73;

    send_vertex(MOST_POS, MOST_POS, MOST_POS, 1'b1);
    send_vertex(MOST_NEG, MOST_NEG, MOST_NEG, 1'b1);
    send_vertex(MOST_NEG, MOST_NEG, MOST_NEG, 1'b0);
    send_vertex(MOST_POS, MOST_POS, MOST_POS, 1'b1);
    send_vertex('0, '0, '0, 1'b1);
    send_vertex(MOST_NEG, '0, '0, 1'b0);
    send_vertex(MOST_POS, '0, '0, 1'b1);
    send_vertex(32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 1'b0);
    send_vertex(32'sh2_0000, 32'sh2_0000, 32'sh2_0000, 1'b0);
    send_vertex(-32'sh5_0000, 32'shA_0000, 32'sh3_0000, 1'b1);
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(3, -5, 7, 1'b1);
    send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    send_vertex(MOST_POS, MOST_NEG, -1, 1'b0);
    send_vertex(MOST_NEG, MOST_POS, 1, 1'b1);

    // hold the output off while single-vertex sets pile up behind it
    hold_asked <= hold_asked + 1;
    repeat (8) send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
    drain_results();

    while (tracker.vertices_taken < 150) send_random_set();
    drain_results();

    sender_idle_pct = 73;
    recv_idle_pct <= 11;
    while (tracker.vertices_taken < 280) send_random_set();
    drain_results();

    sender_idle_pct = 0;
    recv_idle_pct <= 0;
    while (tracker.vertices_taken < 410) send_random_set();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d vertices in %0d sets and checked %0d corner results,",
             tracker.vertices_taken, tracker.sets_closed, tracker.corners_checked);
    $display("under both idle mixes, no idling, and one %0d-cycle output hold-off",
             LONG_HOLD);
    if (tracker.mismatches == 0 && tracker.corners_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d corner results outstanding",
               tracker.mismatches, tracker.corners_due.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/psbv_pkg.sv
design/psbv_queue.sv
design/psbv_front.sv
design/psbv_back.sv
design/point_set_bounding_volumes.sv
design/psbv_checker.sv
tb/sv/testbench.sv
